// ===== rtl/core/apr_pkg.sv =====
package apr_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 2;
  localparam int unsigned RegIdxW = 2;
  localparam logic [ByteW-1:0] CrcPoly = 8'h8C;

  // configuration register indexes
  localparam logic [RegIdxW-1:0] REG_DEST_ADDR = 2'd0;
  localparam logic [RegIdxW-1:0] REG_SRC_ADDR = 2'd1;
  localparam logic [RegIdxW-1:0] REG_ID_FIRST = 2'd2;

  // result event codes
  localparam logic [KindW-1:0] EV_PAYLOAD = 2'd0;
  localparam logic [KindW-1:0] EV_CRC_GOOD = 2'd1;
  localparam logic [KindW-1:0] EV_CRC_ERR = 2'd2;

  typedef enum logic [2:0] {
    PH_HUNT_DEST = 3'd0,
    PH_SRC = 3'd1,
    PH_HDR1 = 3'd2,
    PH_HDR2 = 3'd3,
    PH_LEN = 3'd4,
    PH_DATA = 3'd5,
    PH_CRC = 3'd6
  } phase_t;

  typedef struct packed {
    logic             valid;
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] id;
    logic [ByteW-1:0] num;
    logic [ByteW-1:0] len;
    logic [ByteW-1:0] data;
    logic [ByteW-1:0] index;
  } result_t;

  // reflected crc-8, one byte folded in bit by bit
  function automatic logic [ByteW-1:0] crc8_feed(input logic [ByteW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
    logic [ByteW-1:0] c;
    c = crc ^ b;
    for (int k = 0; k < ByteW; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/apr_deframer.sv =====
module apr_deframer
  import apr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [RegIdxW-1:0] wr_index,
  input  logic [ByteW-1:0]   wr_data,
  input  logic               take,
  input  logic [ByteW-1:0]   rx_byte,
  output result_t            result
);

  logic [ByteW-1:0] dest_addr;
  logic [ByteW-1:0] src_addr;
  logic             id_first;

  phase_t           phase, phase_next;
  logic [ByteW-1:0] hdr1, hdr1_next;
  logic [ByteW-1:0] hdr2, hdr2_next;
  logic [ByteW-1:0] length_held, length_held_next;
  logic [ByteW-1:0] bytes_seen, bytes_seen_next;
  logic [ByteW-1:0] crc, crc_next;
  logic [ByteW-1:0] crc_fed;
  logic [ByteW-1:0] seen_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_addr <= '0;
      src_addr <= '0;
      id_first <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_DEST_ADDR: dest_addr <= wr_data;
        REG_SRC_ADDR:  src_addr <= wr_data;
        REG_ID_FIRST:  id_first <= wr_data[0];
        default: ;
      endcase
    end
  end

  assign crc_fed = crc8_feed(crc, rx_byte);
  assign seen_inc = bytes_seen + 8'd1;

  // next state
  always_comb begin
    phase_next = phase;
    hdr1_next = hdr1;
    hdr2_next = hdr2;
    length_held_next = length_held;
    bytes_seen_next = bytes_seen;
    crc_next = crc;
    unique case (phase)
      PH_SRC: begin
        if (rx_byte == src_addr) begin
          crc_next = '0;
          phase_next = PH_HDR1;
        end else begin
          phase_next = PH_HUNT_DEST;
        end
      end
      PH_HDR1: begin
        hdr1_next = rx_byte;
        crc_next = crc_fed;
        phase_next = PH_HDR2;
      end
      PH_HDR2: begin
        hdr2_next = rx_byte;
        crc_next = crc_fed;
        phase_next = PH_LEN;
      end
      PH_LEN: begin
        length_held_next = rx_byte;
        bytes_seen_next = '0;
        crc_next = crc_fed;
        phase_next = (rx_byte == '0) ? PH_CRC : PH_DATA;
      end
      PH_DATA: begin
        crc_next = crc_fed;
        bytes_seen_next = seen_inc;
        if (seen_inc >= length_held) phase_next = PH_CRC;
      end
      PH_CRC: phase_next = PH_HUNT_DEST;
      default: phase_next = (rx_byte == dest_addr) ? PH_SRC : PH_HUNT_DEST;
    endcase
  end

  // result for the byte on the input
  always_comb begin
    result.valid = 1'b0;
    result.kind = EV_PAYLOAD;
    result.id = id_first ? hdr1 : hdr2;
    result.num = id_first ? hdr2 : hdr1;
    result.len = length_held;
    result.data = rx_byte;
    result.index = '0;
    unique case (phase)
      PH_DATA: begin
        result.valid = take;
        result.index = bytes_seen;
      end
      PH_CRC: begin
        result.valid = take;
        result.kind = (rx_byte == crc) ? EV_CRC_GOOD : EV_CRC_ERR;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT_DEST;
      hdr1 <= '0;
      hdr2 <= '0;
      length_held <= '0;
      bytes_seen <= '0;
      crc <= '0;
    end else if (take) begin
      phase <= phase_next;
      hdr1 <= hdr1_next;
      hdr2 <= hdr2_next;
      length_held <= length_held_next;
      bytes_seen <= bytes_seen_next;
      crc <= crc_next;
    end
  end

endmodule

// ===== rtl/core/apr_out_stage.sv =====
module apr_out_stage
  import apr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  result_t          result,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [KindW-1:0] event_kind,
  output logic [ByteW-1:0] packet_id,
  output logic [ByteW-1:0] packet_number,
  output logic [ByteW-1:0] payload_length,
  output logic [ByteW-1:0] payload_byte,
  output logic [ByteW-1:0] payload_index
);

  // a held result leaving this cycle frees the register for the next one
  assign room = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      event_kind <= result.kind;
      packet_id <= result.id;
      packet_number <= result.num;
      payload_length <= result.len;
      payload_byte <= result.data;
      payload_index <= result.index;
    end
  end

endmodule

// ===== rtl/core/addressed_packet_receiver_crc8_unit.sv =====
// channel  direction  handshake             payload
// in       input      in_valid / in_ready   rx_byte
// out      output     out_valid / out_ready event_kind, packet_id, packet_number,
//                                           payload_length, payload_byte, payload_index
// cfg      input      wr_en (no wait)       wr_index, wr_data
//
// one byte per cycle while in_ready is high; a payload or crc byte shows on the output in the cycle after its transfer
// the crc check and the framing step sit between the state and the output register
// in_ready drops only while a result is held and out_ready is low
// rst is synchronous: hunting for the destination byte, framing and config registers at zero
module addressed_packet_receiver_crc8_unit
  import apr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [RegIdxW-1:0] wr_index,
  input  logic [ByteW-1:0]   wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [ByteW-1:0]   rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [KindW-1:0]   event_kind,
  output logic [ByteW-1:0]   packet_id,
  output logic [ByteW-1:0]   packet_number,
  output logic [ByteW-1:0]   payload_length,
  output logic [ByteW-1:0]   payload_byte,
  output logic [ByteW-1:0]   payload_index
);

  result_t result;
  logic    take;

  assign take = in_valid && in_ready;

  apr_deframer u_deframer (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .take     (take),
    .rx_byte  (rx_byte),
    .result   (result)
  );

  apr_out_stage u_out (
    .clk            (clk),
    .rst            (rst),
    .result         (result),
    .room           (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_kind     (event_kind),
    .packet_id      (packet_id),
    .packet_number  (packet_number),
    .payload_length (payload_length),
    .payload_byte   (payload_byte),
    .payload_index  (payload_index)
  );

endmodule

// ===== rtl/core/apr_checker.sv =====
module apr_checker
  import apr_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [KindW-1:0] event_kind,
  input logic [ByteW-1:0] payload_byte,
  input logic [ByteW-1:0] payload_index
);

  // input side stalls only behind a held result
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low without a stalled result");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(payload_byte)
                                   && $stable(event_kind)))
    else $error("stalled result changed");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (event_kind == EV_PAYLOAD || event_kind == EV_CRC_GOOD
                   || event_kind == EV_CRC_ERR))
    else $error("bad event kind");

  a_end_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_kind != EV_PAYLOAD) |-> (payload_index == '0))
    else $error("end event with nonzero index");

  // a result only follows an input transfer
  a_cause: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) && !(in_valid && in_ready) |=> !out_valid)
    else $error("result without an input transfer");

endmodule

bind addressed_packet_receiver_crc8_unit apr_checker u_apr_checker (.*);

// ===== tb/sv/tb_top.sv =====
module tb_top;
  import apr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TimeoutNs = 4_800_000;
  localparam int RandItems = 1450;
  localparam int RandPhases = 8;
  localparam logic [RegIdxW-1:0] REG_UNUSED = 2'd3;

  typedef logic [ByteW-1:0] byte_q_t[$];

  typedef struct {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] id;
    logic [ByteW-1:0] num;
    logic [ByteW-1:0] len;
    logic [ByteW-1:0] data;
    logic [ByteW-1:0] index;
  } rx_event_t;

  typedef enum {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic               clk;
  logic               rst;
  logic               wr_en;
  logic [RegIdxW-1:0] wr_index;
  logic [ByteW-1:0]   wr_data;
  logic               in_valid;
  logic               in_ready;
  logic [ByteW-1:0]   rx_byte;
  logic               out_valid;
  logic               out_ready;
  logic [KindW-1:0]   event_kind;
  logic [ByteW-1:0]   packet_id;
  logic [ByteW-1:0]   packet_number;
  logic [ByteW-1:0]   payload_length;
  logic [ByteW-1:0]   payload_byte;
  logic [ByteW-1:0]   payload_index;

  addressed_packet_receiver_crc8_unit dut (
    .clk            (clk),
    .rst            (rst),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_kind     (event_kind),
    .packet_id      (packet_id),
    .packet_number  (packet_number),
    .payload_length (payload_length),
    .payload_byte   (payload_byte),
    .payload_index  (payload_index)
  );

  // deframer copy: registers and framing state
  logic [ByteW-1:0] cfg_dest = '0;
  logic [ByteW-1:0] cfg_src = '0;
  logic             cfg_id_first = 1'b0;
  phase_t           frame_phase = PH_HUNT_DEST;
  logic [ByteW-1:0] hdr_first = '0;
  logic [ByteW-1:0] hdr_second = '0;
  logic [ByteW-1:0] len_held = '0;
  logic [ByteW-1:0] data_count = '0;
  logic [ByteW-1:0] crc_acc = '0;

  rx_event_t pending_events[$];

  int mismatches = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  int settings_used = 1;
  int payload_seen = 0;
  int good_ends = 0;
  int bad_ends = 0;
  int burst_left = 1;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(TimeoutNs);
    $display("addressed_packet_receiver_crc8_unit: mismatch");
    $finish;
  end

  // crc-8 reflected, fed lsb first one bit at a time
  function automatic logic [ByteW-1:0] crc_next(input logic [ByteW-1:0] crc,
                                                input logic [ByteW-1:0] b);
    logic [ByteW-1:0] c;
    c = crc;
    for (int i = 0; i < ByteW; i++) begin
      if (c[0] ^ b[i]) begin
        c = {1'b0, c[ByteW-1:1]} ^ CrcPoly;
      end else begin
        c = {1'b0, c[ByteW-1:1]};
      end
    end
    return c;
  endfunction

  function automatic logic [ByteW-1:0] crc_of(input byte_q_t q);
    logic [ByteW-1:0] c;
    c = '0;
    foreach (q[i]) c = crc_next(c, q[i]);
    return c;
  endfunction

  task automatic apply_write(input logic [RegIdxW-1:0] idx, input logic [ByteW-1:0] d);
    case (idx)
      REG_DEST_ADDR: cfg_dest = d;
      REG_SRC_ADDR: cfg_src = d;
      REG_ID_FIRST: cfg_id_first = d[0];
      default: ;
    endcase
  endtask

  task automatic predict_byte(input logic [ByteW-1:0] b);
    rx_event_t ev;
    logic has_event;
    has_event = 1'b0;
    ev.kind = EV_PAYLOAD;
    ev.data = b;
    ev.index = '0;
    case (frame_phase)
      PH_SRC: begin
        if (b == cfg_src) begin
          crc_acc = '0;
          frame_phase = PH_HDR1;
        end else begin
          frame_phase = PH_HUNT_DEST;
        end
      end
      PH_HDR1: begin
        hdr_first = b;
        crc_acc = crc_next(crc_acc, b);
        frame_phase = PH_HDR2;
      end
      PH_HDR2: begin
        hdr_second = b;
        crc_acc = crc_next(crc_acc, b);
        frame_phase = PH_LEN;
      end
      PH_LEN: begin
        len_held = b;
        data_count = '0;
        crc_acc = crc_next(crc_acc, b);
        if (b == '0) begin
          frame_phase = PH_CRC;
        end else begin
          frame_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        ev.index = data_count;
        crc_acc = crc_next(crc_acc, b);
        data_count = data_count + 1'b1;
        if (data_count >= len_held) frame_phase = PH_CRC;
        has_event = 1'b1;
      end
      PH_CRC: begin
        frame_phase = PH_HUNT_DEST;
        if (b == crc_acc) begin
          ev.kind = EV_CRC_GOOD;
        end else begin
          ev.kind = EV_CRC_ERR;
        end
        has_event = 1'b1;
      end
      default: begin
        if (b == cfg_dest) begin
          frame_phase = PH_SRC;
        end else begin
          frame_phase = PH_HUNT_DEST;
        end
      end
    endcase
    if (has_event) begin
      // header order is taken from the register at the moment of the result
      ev.id = cfg_id_first ? hdr_first : hdr_second;
      ev.num = cfg_id_first ? hdr_second : hdr_first;
      ev.len = len_held;
      pending_events.push_back(ev);
    end
  endtask

  function automatic void check_field(input string name, input logic [ByteW-1:0] exp_v,
                                      input logic [ByteW-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  task automatic check_event();
    rx_event_t ev;
    if (pending_events.size() == 0) begin
      $error("result with nothing pending: kind %0d byte %0h", event_kind, payload_byte);
      mismatches++;
    end else begin
      ev = pending_events.pop_front();
      check_field("event_kind", ByteW'(ev.kind), ByteW'(event_kind));
      check_field("packet_id", ev.id, packet_id);
      check_field("packet_number", ev.num, packet_number);
      check_field("payload_length", ev.len, payload_length);
      check_field("payload_byte", ev.data, payload_byte);
      check_field("payload_index", ev.index, payload_index);
      case (ev.kind)
        EV_PAYLOAD: payload_seen++;
        EV_CRC_GOOD: good_ends++;
        default: bad_ends++;
      endcase
    end
  endtask

  // results are checked before the byte of the same edge is predicted
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) check_event();
      if (wr_en) apply_write(wr_index, wr_data);
      if (in_valid && in_ready) predict_byte(rx_byte);
    end
  end

  // receiver stalls in spans of one pattern each
  initial begin
    rx_mode_t mode;
    int span;
    out_ready = 1'b0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(16, 160);
      for (int i = 0; i < span; i++) begin
        @(negedge clk);
        case (mode)
          RX_ALWAYS: out_ready <= 1'b1;
          RX_COIN: out_ready <= ($urandom_range(0, 1) == 1);
          RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (i % 5 == 4);
        endcase
      end
    end
  end

  // valid stays up across a burst; a gap follows each burst
  task automatic send_byte(input logic [ByteW-1:0] b);
    @(negedge clk);
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic in_idle();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // quiet the input, drain results, then allow the last byte to settle
  task automatic settle();
    in_idle();
    while (pending_events.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [ByteW-1:0] d);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= d;
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  function automatic byte_q_t make_body(input int len);
    byte_q_t q;
    q.push_back(8'($urandom));
    q.push_back(8'($urandom));
    q.push_back(8'(len));
    repeat (len) q.push_back(8'($urandom));
    return q;
  endfunction

  // body is header, header, length, payload
  task automatic send_frame(input byte_q_t body, input bit bad_crc);
    logic [ByteW-1:0] crc;
    crc = crc_of(body);
    if (bad_crc) crc = crc ^ 8'($urandom_range(1, 255));
    send_byte(cfg_dest);
    send_byte(cfg_src);
    foreach (body[i]) send_byte(body[i]);
    send_byte(crc);
    frames_sent++;
  endtask

  function automatic int rand_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 88) return $urandom_range(0, 6);
    if (r < 97) return $urandom_range(7, 40);
    return $urandom_range(200, 255);
  endfunction

  task automatic test_reset_values();
    byte_q_t body;
    body = '{8'h00, 8'hFF, 8'h01, 8'hFF};
    send_frame(body, 1'b0);
    settle();
  endtask

  task automatic test_header_order_extremes();
    byte_q_t body;
    write_reg(REG_DEST_ADDR, 8'hFF);
    write_reg(REG_SRC_ADDR, 8'h00);
    write_reg(REG_ID_FIRST, 8'h01);
    // index past the last register must change nothing
    write_reg(REG_UNUSED, 8'hA5);
    settings_used++;
    // zero length with a corrupted check byte
    body = '{8'h12, 8'h34, 8'h00};
    send_frame(body, 1'b1);
    settle();
  endtask

  task automatic test_src_mismatch();
    send_byte(cfg_dest);
    send_byte(cfg_src ^ 8'h80);
    settle();
  endtask

  task automatic test_order_flip_mid_packet();
    byte_q_t body;
    logic [ByteW-1:0] crc;
    body = '{8'h5A, 8'hA5, 8'h02, 8'hFF, 8'h00};
    crc = crc_of(body);
    send_byte(cfg_dest);
    send_byte(cfg_src);
    for (int i = 0; i < 4; i++) send_byte(body[i]);
    settle();
    write_reg(REG_ID_FIRST, {7'h7F, ~cfg_id_first});
    settings_used++;
    send_byte(body[4]);
    send_byte(crc);
    frames_sent++;
    settle();
  endtask

  task automatic test_random_traffic();
    byte_q_t body;
    int phase_items;
    int pick;
    int len;
    int nrand;
    for (int ph = 0; ph < RandPhases; ph++) begin
      settle();
      case (ph)
        0: begin
          write_reg(REG_DEST_ADDR, 8'hFF);
          write_reg(REG_SRC_ADDR, 8'hFF);
          write_reg(REG_ID_FIRST, 8'h01);
        end
        1: begin
          write_reg(REG_DEST_ADDR, 8'h00);
          write_reg(REG_SRC_ADDR, 8'hFF);
          write_reg(REG_ID_FIRST, 8'hFE);
        end
        default: begin
          write_reg(REG_DEST_ADDR, 8'($urandom));
          write_reg(REG_SRC_ADDR, 8'($urandom));
          write_reg(REG_ID_FIRST, 8'($urandom));
          if ($urandom_range(0, 1) == 1) write_reg(REG_UNUSED, 8'($urandom));
        end
      endcase
      settings_used++;
      phase_items = 0;
      if (ph == 2) begin
        // longest payload, indexes up to 254
        body = make_body(255);
        send_frame(body, 1'b0);
        phase_items += 258;
      end
      while (phase_items < RandItems / RandPhases) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          len = rand_len();
          body = make_body(len);
          send_frame(body, $urandom_range(0, 6) == 0);
          phase_items += len + 6;
        end else if (pick < 80) begin
          send_byte(cfg_dest);
          send_byte(cfg_src ^ 8'($urandom_range(1, 255)));
          phase_items += 2;
        end else if (pick < 90) begin
          // frame cut before its check byte; what follows is taken as its tail
          body = make_body($urandom_range(1, 6));
          send_byte(cfg_dest);
          send_byte(cfg_src);
          foreach (body[i]) send_byte(body[i]);
          phase_items += body.size() + 2;
        end else begin
          nrand = $urandom_range(1, 6);
          repeat (nrand) send_byte(8'($urandom));
          phase_items += nrand;
        end
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    in_valid = 1'b0;
    rx_byte = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    burst_left = $urandom_range(1, 40);

    test_reset_values();
    test_header_order_extremes();
    test_src_mismatch();
    test_order_flip_mid_packet();
    test_random_traffic();

    settle();
    repeat (8) @(posedge clk);
    $display("covered %0d bytes, %0d framed packets, %0d register settings",
             bytes_sent, frames_sent, settings_used);
    $display("checked %0d payload bytes, %0d good-crc and %0d crc-error packet ends",
             payload_seen, good_ends, bad_ends);
    if (mismatches == 0) begin
      $display("addressed_packet_receiver_crc8_unit: match");
    end else begin
      $display("addressed_packet_receiver_crc8_unit: mismatch");
    end
    $finish;
  end

endmodule
